[rtl/reservation_station_issue_wakeup_select_core_assert.svh]
// Assertion macros for the reservation station RTL.
`ifndef RESERVATION_STATION_ISSUE_WAKEUP_SELECT_CORE_ASSERT_SVH
`define RESERVATION_STATION_ISSUE_WAKEUP_SELECT_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define RSIWS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reservation station check failed");

// Next-cycle implication.
`define RSIWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reservation station check failed");

`endif

[rtl/rsiws_pkg.sv]
package rsiws_pkg;

  localparam int CMD_W     = 2;
  localparam int OP_W      = 2;
  localparam int AGE_W     = 16;
  localparam int LAT_W     = 6;
  localparam int KIND_W    = 2;
  localparam int ENTRY_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_LAT   = 4;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ISSUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BCAST = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ISSUE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

  localparam logic [LAT_W-1:0] LAT_RST_OP0 = 6'd2;
  localparam logic [LAT_W-1:0] LAT_RST_OP1 = 6'd2;
  localparam logic [LAT_W-1:0] LAT_RST_OP2 = 6'd10;
  localparam logic [LAT_W-1:0] LAT_RST_OP3 = 6'd40;

  typedef struct packed {
    logic issue;
    logic bcast;
    logic tick;
    logic start;
  } cell_ctrl_t;

  typedef struct packed {
    logic busy;
    logic running;
    logic done;
  } cell_stat_t;

endpackage

[rtl/rsiws_cell.sv]
module rsiws_cell
  import rsiws_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int IDXW       = 2,
  parameter int DATA_WIDTH = 32,
  parameter int TAG_WIDTH  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctrl_t            ctrl,
  input  logic [OP_W-1:0]       iss_op,
  input  logic                  iss_src1_pending,
  input  logic [DATA_WIDTH-1:0] iss_src1,
  input  logic                  iss_src2_pending,
  input  logic [DATA_WIDTH-1:0] iss_src2,
  input  logic [AGE_W-1:0]      iss_age,
  input  logic [TAG_WIDTH-1:0]  cdb_tag,
  input  logic [DATA_WIDTH-1:0] cdb_value,
  input  logic [LAT_W-1:0]      start_lat,
  input  logic                  scan_in_valid,
  input  logic [AGE_W-1:0]      scan_in_age,
  input  logic [IDXW-1:0]       scan_in_idx,
  output logic                  scan_out_valid,
  output logic [AGE_W-1:0]      scan_out_age,
  output logic [IDXW-1:0]       scan_out_idx,
  output cell_stat_t            stat,
  output logic [OP_W-1:0]       opcode,
  output logic [DATA_WIDTH-1:0] data1,
  output logic [DATA_WIDTH-1:0] data2
);

  logic                  busy_r, running_r, wait1_r, wait2_r;
  logic [LAT_W-1:0]      cnt_r;
  logic [OP_W-1:0]       op_r;
  logic [DATA_WIDTH-1:0] d1_r, d2_r;
  logic [AGE_W-1:0]      age_r;
  logic                  sv_r;
  logic [AGE_W-1:0]      sa_r;
  logic [IDXW-1:0]       si_r;
  logic [DATA_WIDTH-1:0] tag_ext;
  logic                  hit1, hit2, eligible, take;

  assign tag_ext  = DATA_WIDTH'(cdb_tag);
  assign hit1     = ctrl.bcast && busy_r && wait1_r && (d1_r == tag_ext);
  assign hit2     = ctrl.bcast && busy_r && wait2_r && (d2_r == tag_ext);
  assign eligible = busy_r && !running_r && !wait1_r && !wait2_r;
  // A later cell wins only when strictly older, so ties keep the lower index.
  assign take     = eligible && (!scan_in_valid || (age_r < scan_in_age));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      running_r <= 1'b0;
      wait1_r   <= 1'b0;
      wait2_r   <= 1'b0;
      sv_r      <= 1'b0;
    end else begin
      sv_r <= take || scan_in_valid;
      if (ctrl.issue) begin
        busy_r    <= 1'b1;
        running_r <= 1'b0;
        wait1_r   <= iss_src1_pending;
        wait2_r   <= iss_src2_pending;
      end else if (ctrl.tick && busy_r && running_r) begin
        if (cnt_r == '0) begin
          busy_r    <= 1'b0;
          running_r <= 1'b0;
          wait1_r   <= 1'b0;
          wait2_r   <= 1'b0;
        end
      end else if (ctrl.start) begin
        running_r <= 1'b1;
      end else begin
        if (hit1) wait1_r <= 1'b0;
        if (hit2) wait2_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sa_r <= take ? age_r : scan_in_age;
    si_r <= take ? IDXW'(IDX) : scan_in_idx;
    if (ctrl.issue) begin
      op_r  <= iss_op;
      age_r <= iss_age;
      d1_r  <= iss_src1_pending ? DATA_WIDTH'(iss_src1[TAG_WIDTH-1:0]) : iss_src1;
      d2_r  <= iss_src2_pending ? DATA_WIDTH'(iss_src2[TAG_WIDTH-1:0]) : iss_src2;
    end else begin
      if (hit1) d1_r <= cdb_value;
      if (hit2) d2_r <= cdb_value;
    end
    if (ctrl.start) begin
      cnt_r <= start_lat;
    end else if (ctrl.tick && busy_r && running_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign scan_out_valid = sv_r;
  assign scan_out_age   = sa_r;
  assign scan_out_idx   = si_r;
  assign stat.busy      = busy_r;
  assign stat.running   = running_r;
  assign stat.done      = busy_r && running_r && (cnt_r == '0);
  assign opcode         = op_r;
  assign data1          = d1_r;
  assign data2          = d2_r;

endmodule

[rtl/reservation_station_issue_wakeup_select_core.sv]
// Reservation station group with round-robin issue, tag wakeup and oldest-first
// select. Issue, broadcast and unknown commands each give a single result beat.
// A tick gives one result beat per completion, or one beat when nothing
// completes, after its select passes: none when every unit is already
// running, otherwise one per entry started plus one more when the ready entries
// run out before the free units do. Each pass runs a scan token through the row
// of entry cells, one cell per cycle, and result beats leave one per cycle in
// entry order while the receiver is ready. The next item is taken the cycle
// after the last result beat has been taken.
module reservation_station_issue_wakeup_select_core
  import rsiws_pkg::*;
#(
  parameter int NUM_ENTRIES = 4,
  parameter int NUM_UNITS   = 2,
  parameter int DATA_WIDTH  = 32,
  parameter int TAG_WIDTH   = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [OP_W-1:0]       in_op,
  input  logic                  in_src1_pending,
  input  logic [DATA_WIDTH-1:0] in_src1,
  input  logic                  in_src2_pending,
  input  logic [DATA_WIDTH-1:0] in_src2,
  input  logic [AGE_W-1:0]      in_issue_time,
  input  logic [TAG_WIDTH-1:0]  in_cdb_tag,
  input  logic [DATA_WIDTH-1:0] in_cdb_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_kind,
  output logic                  out_accepted,
  output logic [ENTRY_W-1:0]    out_entry,
  output logic [OP_W-1:0]       out_result_op,
  output logic [DATA_WIDTH-1:0] out_operand1,
  output logic [DATA_WIDTH-1:0] out_operand2,
  output logic                  out_last,
  output logic                  out_all_free,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LAT_W-1:0]      cfg_wdata
);

  `include "reservation_station_issue_wakeup_select_core_assert.svh"

  localparam int IDXW = $clog2(NUM_ENTRIES);
  localparam int CNTW = $clog2(NUM_ENTRIES + 1);
  localparam int PKW  = $clog2(NUM_UNITS + 1);

  typedef enum logic [2:0] {S_IDLE, S_REPLY, S_COUNT, S_SCAN, S_EMIT} state_t;

  state_t                state_r;
  logic [LAT_W-1:0]      lat_r [NUM_LAT];
  logic [IDXW-1:0]       alloc_ptr_r;
  logic [KIND_W-1:0]     rep_kind_r;
  logic                  rep_acc_r;
  logic [ENTRY_W-1:0]    rep_entry_r;
  logic [NUM_ENTRIES-1:0] mask_r;
  logic [PKW-1:0]        picks_r;
  logic [CNTW-1:0]       scan_cnt_r;

  logic                  out_valid_r, out_acc_r, out_last_r, out_all_free_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic [ENTRY_W-1:0]    out_entry_r;
  logic [OP_W-1:0]       out_op_r;
  logic [DATA_WIDTH-1:0] out_d1_r, out_d2_r;

  cell_ctrl_t            ctrl [NUM_ENTRIES];
  cell_stat_t            stat [NUM_ENTRIES];
  logic [OP_W-1:0]       cell_op [NUM_ENTRIES];
  logic [DATA_WIDTH-1:0] cell_d1 [NUM_ENTRIES];
  logic [DATA_WIDTH-1:0] cell_d2 [NUM_ENTRIES];
  logic                  scan_v   [NUM_ENTRIES+1];
  logic [AGE_W-1:0]      scan_age [NUM_ENTRIES+1];
  logic [IDXW-1:0]       scan_idx [NUM_ENTRIES+1];

  logic                  fire, out_load, out_set, any_busy, iss_ok;
  logic                  found_v, pick_now, low_v, low_last;
  logic [IDXW-1:0]       found_idx, low_idx;
  logic [NUM_ENTRIES-1:0] busy_vec, run_vec, done_vec;
  logic [CNTW-1:0]       run_cnt;
  logic [LAT_W-1:0]      pick_lat, start_lat;

  assign fire     = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_load = !out_valid_r || out_ready;
  assign out_set  = ((state_r == S_REPLY) || (state_r == S_EMIT)) && out_load;
  assign iss_ok   = (in_command == CMD_ISSUE) && found_v;

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      busy_vec[i] = stat[i].busy;
      run_vec[i]  = stat[i].running;
      done_vec[i] = stat[i].done;
    end
  end
  assign any_busy = |busy_vec;
  assign run_cnt  = CNTW'($countones(run_vec));

  // Round-robin free search: the nearest free entry after the pointer wins.
  always_comb begin
    int p;
    found_v   = 1'b0;
    found_idx = '0;
    for (int n = NUM_ENTRIES; n >= 1; n--) begin
      p = int'(alloc_ptr_r) + n;
      if (p >= NUM_ENTRIES) p = p - NUM_ENTRIES;
      if (!busy_vec[IDXW'(p)]) begin
        found_v   = 1'b1;
        found_idx = IDXW'(p);
      end
    end
  end

  always_comb begin
    low_v   = 1'b0;
    low_idx = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_v   = 1'b1;
        low_idx = IDXW'(i);
      end
    end
  end
  assign low_last = (mask_r & ~(NUM_ENTRIES'(1) << low_idx)) == '0;

  assign pick_now  = (state_r == S_SCAN) && (scan_cnt_r == CNTW'(NUM_ENTRIES))
                     && scan_v[NUM_ENTRIES];
  assign pick_lat  = lat_r[cell_op[scan_idx[NUM_ENTRIES]]];
  assign start_lat = (pick_lat == '0) ? LAT_W'(1) : pick_lat;

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      ctrl[i].issue = fire && (in_command == CMD_ISSUE) && found_v && (found_idx == IDXW'(i));
      ctrl[i].bcast = fire && (in_command == CMD_BCAST);
      ctrl[i].tick  = fire && (in_command == CMD_TICK);
      ctrl[i].start = pick_now && (scan_idx[NUM_ENTRIES] == IDXW'(i));
    end
  end

  assign scan_v[0]   = 1'b0;
  assign scan_age[0] = '0;
  assign scan_idx[0] = '0;

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    rsiws_cell #(
      .IDX        (g),
      .IDXW       (IDXW),
      .DATA_WIDTH (DATA_WIDTH),
      .TAG_WIDTH  (TAG_WIDTH)
    ) u_cell (
      .clk              (clk),
      .rst_n            (rst_n),
      .ctrl             (ctrl[g]),
      .iss_op           (in_op),
      .iss_src1_pending (in_src1_pending),
      .iss_src1         (in_src1),
      .iss_src2_pending (in_src2_pending),
      .iss_src2         (in_src2),
      .iss_age          (in_issue_time),
      .cdb_tag          (in_cdb_tag),
      .cdb_value        (in_cdb_value),
      .start_lat        (start_lat),
      .scan_in_valid    (scan_v[g]),
      .scan_in_age      (scan_age[g]),
      .scan_in_idx      (scan_idx[g]),
      .scan_out_valid   (scan_v[g+1]),
      .scan_out_age     (scan_age[g+1]),
      .scan_out_idx     (scan_idx[g+1]),
      .stat             (stat[g]),
      .opcode           (cell_op[g]),
      .data1            (cell_d1[g]),
      .data2            (cell_d2[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r[0] <= LAT_RST_OP0;
      lat_r[1] <= LAT_RST_OP1;
      lat_r[2] <= LAT_RST_OP2;
      lat_r[3] <= LAT_RST_OP3;
    end else if (cfg_we) begin
      lat_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alloc_ptr_r <= IDXW'(NUM_ENTRIES - 1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (fire) begin
            rep_acc_r   <= iss_ok;
            rep_entry_r <= iss_ok ? ENTRY_W'(found_idx) : '0;
            rep_kind_r  <= (in_command == CMD_ISSUE) ? KIND_ISSUE : KIND_NONE;
            state_r     <= (in_command == CMD_TICK) ? S_COUNT : S_REPLY;
            if (iss_ok) alloc_ptr_r <= found_idx;
          end
        end
        S_REPLY: begin
          if (out_load) begin
            out_kind_r     <= rep_kind_r;
            out_acc_r      <= rep_acc_r;
            out_entry_r    <= rep_entry_r;
            out_op_r       <= '0;
            out_d1_r       <= '0;
            out_d2_r       <= '0;
            out_last_r     <= 1'b1;
            out_all_free_r <= !any_busy;
            state_r        <= S_IDLE;
          end
        end
        S_COUNT: begin
          mask_r     <= done_vec;
          scan_cnt_r <= '0;
          if (int'(run_cnt) < NUM_UNITS) begin
            picks_r <= PKW'(NUM_UNITS - int'(run_cnt));
            state_r <= S_SCAN;
          end else begin
            picks_r <= '0;
            state_r <= S_EMIT;
          end
        end
        S_SCAN: begin
          scan_cnt_r <= (scan_cnt_r == CNTW'(NUM_ENTRIES)) ? '0 : scan_cnt_r + 1'b1;
          if (scan_cnt_r == CNTW'(NUM_ENTRIES)) begin
            if (!scan_v[NUM_ENTRIES] || picks_r == PKW'(1)) state_r <= S_EMIT;
            if (scan_v[NUM_ENTRIES]) picks_r <= picks_r - 1'b1;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_acc_r      <= 1'b0;
            out_all_free_r <= !any_busy;
            if (low_v) begin
              out_kind_r  <= KIND_DONE;
              out_entry_r <= ENTRY_W'(low_idx);
              out_op_r    <= cell_op[low_idx];
              out_d1_r    <= cell_d1[low_idx];
              out_d2_r    <= cell_d2[low_idx];
              out_last_r  <= low_last;
              mask_r[low_idx] <= 1'b0;
              if (low_last) state_r <= S_IDLE;
            end else begin
              out_kind_r  <= KIND_NONE;
              out_entry_r <= '0;
              out_op_r    <= '0;
              out_d1_r    <= '0;
              out_d2_r    <= '0;
              out_last_r  <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_accepted  = out_acc_r;
  assign out_entry     = out_entry_r;
  assign out_result_op = out_op_r;
  assign out_operand1  = out_d1_r;
  assign out_operand2  = out_d2_r;
  assign out_last      = out_last_r;
  assign out_all_free  = out_all_free_r;

  `RSIWS_ASSERT_NEXT(a_busy_after_accept, fire, state_r != S_IDLE)
  `RSIWS_ASSERT_NOW(a_units_bounded, state_r == S_IDLE, int'(run_cnt) <= NUM_UNITS)
  `RSIWS_ASSERT_NOW(a_scan_has_pick, state_r == S_SCAN, picks_r != '0)
  `RSIWS_ASSERT_NEXT(a_issue_takes_entry, fire && in_command == CMD_ISSUE && found_v,
                     busy_vec[$past(found_idx)])

endmodule
